[rtl/rgb_to_hsv_converter_macros.svh]
// ---------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms for the converter RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBHSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGBHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rgbhsv_pkg.sv]
// ---------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, sextant codes and shared helper functions.
// ---------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 16;

    // Divider geometry: 24-bit dividend, 16 quotient bits, 8-bit divisor.
    localparam int DIV_DW = 24;
    localparam int DIV_QW = 16;

    // Hue of one sextant, degrees times 64.
    localparam int SEXT_HUE = 3840;

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } t_sext;

    typedef struct packed {
        t_sext             sext;
        logic [CHAN_W-1:0] bri;
        logic              grey;
        logic              black;
    } t_side;

    // Base hue of a sextant.
    function automatic logic [HUE_W-1:0] sext_base(input t_sext s);
        logic [HUE_W-1:0] v;
        case (s)
            SEXT_0:  v = HUE_W'(0 * SEXT_HUE);
            SEXT_1:  v = HUE_W'(1 * SEXT_HUE);
            SEXT_2:  v = HUE_W'(2 * SEXT_HUE);
            SEXT_3:  v = HUE_W'(3 * SEXT_HUE);
            SEXT_4:  v = HUE_W'(4 * SEXT_HUE);
            SEXT_5:  v = HUE_W'(5 * SEXT_HUE);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/rgbhsv_ifs.sv]
// ---------------------------------------------------------------------------
// RGB to HSV converter channel interfaces
// Valid/ready channels for the RGB pixel input and the HSV result.
// ---------------------------------------------------------------------------
interface rgbhsv_pix_if;
    logic                           valid;
    logic                           ready;
    logic [rgbhsv_pkg::CHAN_W-1:0]  red_in;
    logic [rgbhsv_pkg::CHAN_W-1:0]  green_in;
    logic [rgbhsv_pkg::CHAN_W-1:0]  blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rgbhsv_hsv_if;
    logic                           valid;
    logic                           ready;
    logic [rgbhsv_pkg::HUE_W-1:0]   hue_out;
    logic [rgbhsv_pkg::SAT_W-1:0]   sat_out;
    logic [rgbhsv_pkg::CHAN_W-1:0]  bri_out;

    modport source (output valid, output hue_out, output sat_out, output bri_out,
                    input ready);
    modport sink   (input valid, input hue_out, input sat_out, input bri_out,
                    output ready);
endinterface

[rtl/rgbhsv_div.sv]
// ---------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, one quotient bit per stage; quotient must fit QW bits.
// ---------------------------------------------------------------------------
module rgbhsv_div #(
    parameter int DW = 24,
    parameter int QW = 16,
    parameter int NW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [NW-1:0] r_den [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_stage
            logic [NW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [NW-1:0] den_in;
            logic [NW:0]   trial;
            logic [NW:0]   diff;
            logic          ge;
            logic [NW-1:0] n_rem;
            logic [QW-1:0] n_low;

            if (s == 0) begin : g_first
                assign rem_in = NW'(i_num[DW-1:QW]);
                assign low_in = i_num[QW-1:0];
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[s-1];
                assign low_in = r_low[s-1];
                assign den_in = r_den[s-1];
            end

            // Shift in the next dividend bit, subtract when it fits.
            assign trial = {rem_in, low_in[QW-1]};
            assign diff  = trial - {1'b0, den_in};
            assign ge    = (trial >= {1'b0, den_in});
            assign n_rem = ge ? diff[NW-1:0] : trial[NW-1:0];
            assign n_low = {low_in[QW-2:0], ge};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_low[s] <= n_low;
                    r_den[s] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_low[QW-1];

endmodule

[rtl/rgb_to_hsv_converter.sv]
// Pipeline: decode stage A, the divide stages and the output stage lie between input beat and result beat.
// Throughput: one pixel per cycle while the result beat is not stalled; one quotient bit is resolved per divider stage.
// A stalled result beat freezes the whole pipeline; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload is not reset.
// ---------------------------------------------------------------------------
// RGB to HSV converter
// Brightness, Q1.15 saturation and hue in degrees times 64 for 8-bit RGB.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rgbhsv_pix_if.sink        i_pix,
    rgbhsv_hsv_if.source      o_hsv
);

    localparam int QW = rgbhsv_pkg::DIV_QW;
    localparam int DW = rgbhsv_pkg::DIV_DW;
    localparam int CW = rgbhsv_pkg::CHAN_W;

    logic r_o_vld;

    // Global advance: move every stage when the output slot is free or taken.
    logic en;
    assign en          = !r_o_vld || o_hsv.ready;
    assign i_pix.ready = en;

    // -----------------------------------------------------------------------
    // Stage A: find max/min, sextant and in-sextant difference.
    // -----------------------------------------------------------------------
    logic [CW-1:0] red, grn, blu;
    logic          r_is_max, g_is_max;
    logic [CW-1:0] cmax, cmin, delta, e;
    rgbhsv_pkg::t_sext sext;
    logic [11:0]   e15;

    assign red = i_pix.red_in;
    assign grn = i_pix.green_in;
    assign blu = i_pix.blue_in;

    always_comb begin
        // Red wins ties over green, green over blue.
        r_is_max = (red >= grn) && (red >= blu);
        g_is_max = !r_is_max && (grn >= blu);
        if (r_is_max) begin
            cmax = red;
            cmin = (grn < blu) ? grn : blu;
            if (grn >= blu) begin
                sext = rgbhsv_pkg::SEXT_0;
                e    = grn - blu;
            end else begin
                sext = rgbhsv_pkg::SEXT_5;
                e    = red - blu;
            end
        end else if (g_is_max) begin
            cmax = grn;
            cmin = (red < blu) ? red : blu;
            if (blu >= red) begin
                sext = rgbhsv_pkg::SEXT_2;
                e    = blu - red;
            end else begin
                sext = rgbhsv_pkg::SEXT_1;
                e    = grn - red;
            end
        end else begin
            cmax = blu;
            cmin = (red < grn) ? red : grn;
            if (red >= grn) begin
                sext = rgbhsv_pkg::SEXT_4;
                e    = red - grn;
            end else begin
                sext = rgbhsv_pkg::SEXT_3;
                e    = blu - grn;
            end
        end
        delta = cmax - cmin;
        // 15 * e, fits 12 bits
        e15 = {e, 4'b0000} - 12'(e);
    end

    logic                 r_a_vld;
    rgbhsv_pkg::t_side    r_a_side;
    logic [DW-1:0]        r_a_hnum;
    logic [DW-1:0]        r_a_snum;
    logic [CW-1:0]        r_a_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side.sext  <= sext;
            r_a_side.bri   <= cmax;
            r_a_side.grey  <= (delta == '0);
            r_a_side.black <= (cmax == '0);
            // Hue dividend: 3840 * e = (15 * e) << 8
            r_a_hnum       <= {4'b0000, e15, 8'b0};
            // Saturation dividend: delta << 15
            r_a_snum       <= {1'b0, delta, 15'b0};
            r_a_delta      <= delta;
        end
    end

    // -----------------------------------------------------------------------
    // Divide stages: hue fraction and saturation in parallel.
    // -----------------------------------------------------------------------
    logic [QW-1:0] hue_q, sat_q;

    rgbhsv_div #(.DW(DW), .QW(QW), .NW(CW)) u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_hnum),
        .i_den (r_a_delta),
        .o_quo (hue_q)
    );

    rgbhsv_div #(.DW(DW), .QW(QW), .NW(CW)) u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_a_snum),
        .i_den (r_a_side.bri),
        .o_quo (sat_q)
    );

    // Side data and valid bits travel alongside the divider stages.
    logic              r_vld  [QW];
    rgbhsv_pkg::t_side r_side [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QW; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_a_vld;
            for (int i = 1; i < QW; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_a_side;
            for (int i = 1; i < QW; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Output stage: add sextant base, zero grey hue and black saturation.
    // -----------------------------------------------------------------------
    rgbhsv_pkg::t_side             tail;
    logic [rgbhsv_pkg::HUE_W-1:0]  n_hue;
    logic [rgbhsv_pkg::SAT_W-1:0]  n_sat;

    assign tail  = r_side[QW-1];
    // In-sextant quotient never exceeds 3840, so 12 bits hold it.
    assign n_hue = tail.grey ? '0
                 : rgbhsv_pkg::sext_base(tail.sext) + rgbhsv_pkg::HUE_W'(hue_q[11:0]);
    assign n_sat = tail.black ? '0 : sat_q;

    logic [rgbhsv_pkg::HUE_W-1:0]  r_o_hue;
    logic [rgbhsv_pkg::SAT_W-1:0]  r_o_sat;
    logic [CW-1:0]                 r_o_bri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_vld[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hue <= n_hue;
            r_o_sat <= n_sat;
            r_o_bri <= tail.bri;
        end
    end

    assign o_hsv.valid   = r_o_vld;
    assign o_hsv.hue_out = r_o_hue;
    assign o_hsv.sat_out = r_o_sat;
    assign o_hsv.bri_out = r_o_bri;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `RGBHSV_ASSERT_NOW(a_black_zero, i_clk, i_rst_n, r_o_vld && (r_o_bri == '0), (r_o_sat == '0) && (r_o_hue == '0), "black pixel with nonzero hue or saturation")
    `RGBHSV_ASSERT_NOW(a_range, i_clk, i_rst_n, r_o_vld, (r_o_hue < 15'd23040) && (r_o_sat <= 16'd32768), "hue or saturation out of range")
    `RGBHSV_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !en, $stable(r_a_vld) && $stable(r_o_vld) && $stable(r_o_hue), "pipeline moved during a stall")
    `RGBHSV_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_pix.valid && en, r_a_vld, "accepted beat lost at stage A")

endmodule
